FILE: hw/rtl/permissive_utf8_decoder_defines.svh
// ----------------------------------------------------------------------------
// permissive_utf8_decoder_defines.svh
// Assertion macros shared by the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef PERMISSIVE_UTF8_DECODER_DEFINES_SVH
`define PERMISSIVE_UTF8_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PU8D_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("pu8d: same-cycle property violated");

// Next-cycle implication, disabled while in reset.
`define PU8D_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("pu8d: next-cycle property violated");

`endif

FILE: hw/rtl/pu8d_pkg.sv
// ----------------------------------------------------------------------------
// pu8d_pkg
// Types and constants of the permissive UTF-8 decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pu8d_pkg;

    localparam int CP_W       = 21;
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int REM_W      = 2;
    localparam int RES_CNT_W  = 2;
    localparam int CONT_SHIFT = 6;
    localparam int MAX_RES    = 2;

    // Result buffer depth: one slot draining plus room for a two-result byte.
    localparam int Q_DEPTH    = 3;
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RAW      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CUT      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END      = 2'd3;

    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_BITS  = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_BITS  = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_BITS  = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE   = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_BITS   = 8'h3F;

    typedef struct packed {
        logic [CP_W-1:0]   code_point;
        logic [KIND_W-1:0] result_kind;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0] count;
        result_t              first;
        result_t              second;
    } push_t;

    typedef struct packed {
        push_t             push;
        logic [CP_W-1:0]   partial_next;
        logic [REM_W-1:0]  remaining_next;
    } decode_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pu8d_if.sv
// ----------------------------------------------------------------------------
// pu8d_if
// Valid/ready channels of the decoder: input bytes and decoded results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pu8d_byte_if;
    import pu8d_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface pu8d_result_if;
    import pu8d_pkg::*;

    logic              valid;
    logic              ready;
    logic [CP_W-1:0]   code_point;
    logic [KIND_W-1:0] result_kind;
    logic              last;

    modport source (output valid, output code_point, output result_kind, output last,
                    input ready);
    modport sink   (input valid, input code_point, input result_kind, input last,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pu8d_decode.sv
// ----------------------------------------------------------------------------
// pu8d_decode
// Single-pass byte decode: from the incoming byte and the open sequence,
// produce zero, one or two results and the next sequence state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pu8d_decode (
    input  wire logic [pu8d_pkg::BYTE_W-1:0] data_byte,
    input  wire logic [pu8d_pkg::CP_W-1:0]   partial,
    input  wire logic [pu8d_pkg::REM_W-1:0]  remaining,
    output pu8d_pkg::decode_t                dec
);
    import pu8d_pkg::*;

    logic              is_cont;
    logic              lead_hit;
    result_t           lead_res;
    logic [CP_W-1:0]   lead_part;
    logic [REM_W-1:0]  lead_rem;
    logic [CP_W-1:0]   shifted;
    logic [REM_W-1:0]  rem_dec;

    assign is_cont = (data_byte & CONT_MASK) == CONT_CODE;
    assign shifted = {partial[CP_W-CONT_SHIFT-1:0], data_byte[CONT_SHIFT-1:0]};
    assign rem_dec = remaining - REM_W'(1);

    // Handling of a byte with no sequence open.
    always_comb
    begin
        lead_hit  = 1'b1;
        lead_res  = '{code_point: CP_W'(data_byte), result_kind: KIND_RAW, last: 1'b1};
        lead_part = '0;
        lead_rem  = '0;
        priority if (data_byte == '0)
        begin
            lead_res = '{code_point: '0, result_kind: KIND_END, last: 1'b1};
        end
        else if (data_byte < ASCII_LIMIT)
        begin
            lead_res = '{code_point: CP_W'(data_byte), result_kind: KIND_COMPLETE,
                         last: 1'b1};
        end
        else if ((data_byte & LEAD2_MASK) == LEAD2_CODE)
        begin
            lead_hit  = 1'b0;
            lead_part = CP_W'(data_byte & LEAD2_BITS);
            lead_rem  = REM_W'(1);
        end
        else if ((data_byte & LEAD3_MASK) == LEAD3_CODE)
        begin
            lead_hit  = 1'b0;
            lead_part = CP_W'(data_byte & LEAD3_BITS);
            lead_rem  = REM_W'(2);
        end
        else if ((data_byte & LEAD4_MASK) == LEAD4_CODE)
        begin
            lead_hit  = 1'b0;
            lead_part = CP_W'(data_byte & LEAD4_BITS);
            lead_rem  = REM_W'(3);
        end
        else
        begin
            // stray continuation or 0xF8 and up: pass through as Latin-1
            lead_res = '{code_point: CP_W'(data_byte), result_kind: KIND_RAW, last: 1'b1};
        end
    end

    always_comb
    begin
        dec = '0;
        priority if (remaining != '0 && is_cont)
        begin
            if (rem_dec == '0)
            begin
                dec.push.count = RES_CNT_W'(1);
                dec.push.first = '{code_point: shifted, result_kind: KIND_COMPLETE,
                                   last: 1'b1};
            end
            else
            begin
                dec.partial_next   = shifted;
                dec.remaining_next = rem_dec;
            end
        end
        else if (remaining != '0)
        begin
            // cut short: flush the partial value, then treat the byte as a lead
            dec.push.first     = '{code_point: partial, result_kind: KIND_CUT,
                                   last: !lead_hit};
            dec.push.second    = lead_res;
            dec.push.count     = lead_hit ? RES_CNT_W'(2) : RES_CNT_W'(1);
            dec.partial_next   = lead_part;
            dec.remaining_next = lead_rem;
        end
        else
        begin
            dec.push.first     = lead_res;
            dec.push.count     = lead_hit ? RES_CNT_W'(1) : RES_CNT_W'(0);
            dec.partial_next   = lead_part;
            dec.remaining_next = lead_rem;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pu8d_queue.sv
// ----------------------------------------------------------------------------
// pu8d_queue
// Small shifting result buffer: takes up to two results per cycle, presents
// the oldest at its head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pu8d_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_en,
    input  wire pu8d_pkg::push_t push,
    input  wire logic            pop,
    output pu8d_pkg::result_t    head,
    output logic                 head_valid,
    output logic                 room
);
    import pu8d_pkg::*;

    result_t              q_reg   [Q_DEPTH];
    result_t              q_next  [Q_DEPTH];
    result_t              shifted [Q_DEPTH];
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic [Q_CNT_W-1:0]   base;
    logic [Q_CNT_W-1:0]   base_plus;

    assign head       = q_reg[0];
    assign head_valid = count_reg != '0;
    assign base       = count_reg - Q_CNT_W'(pop);
    assign base_plus  = base + Q_CNT_W'(1);
    // a byte may bring two results, so keep that much space after the pop
    assign room       = base <= Q_CNT_W'(Q_DEPTH - MAX_RES);

    always_comb
    begin
        for (int i = 0; i < Q_DEPTH - 1; i++)
        begin
            shifted[i] = pop ? q_reg[i + 1] : q_reg[i];
        end
        shifted[Q_DEPTH-1] = q_reg[Q_DEPTH-1];

        for (int i = 0; i < Q_DEPTH; i++)
        begin
            q_next[i] = shifted[i];
            if (push_en && push.count != '0 && Q_CNT_W'(i) == base)
            begin
                q_next[i] = push.first;
            end
            if (push_en && push.count == RES_CNT_W'(2) && Q_CNT_W'(i) == base_plus)
            begin
                q_next[i] = push.second;
            end
        end

        count_next = push_en ? base + Q_CNT_W'(push.count) : base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/permissive_utf8_decoder.sv
// Permissive UTF-8 decoder. Bytes enter on byte_stream, one per transfer; codepoints
// leave on code_stream, each tagged complete, raw, cut short or end of string,
// with last marking the final result of its byte. The block takes one byte per
// cycle while the result buffer has room: decode is a single combinational pass
// from the accepted byte and the open-sequence registers into a three-entry
// result buffer, so each result is registered straight into the buffer. A byte
// that ends a cut-short sequence and also gives its own result fills two buffer
// slots while the output drains one result per cycle when code_stream is ready.
// The buffer absorbs the extra result of one such byte; further two-result bytes
// that arrive before it has drained stall byte_stream. Continuation bytes that
// complete nothing give no result and let the buffer catch up.
// ----------------------------------------------------------------------------
// permissive_utf8_decoder
// Top level: sequence state registers, byte decode and result buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module permissive_utf8_decoder (
    input  wire logic      clk,
    input  wire logic      rst_n,
    pu8d_byte_if.sink      byte_stream,
    pu8d_result_if.source  code_stream
);
    import pu8d_pkg::*;

    logic [CP_W-1:0]   partial_reg;
    logic [CP_W-1:0]   partial_next;
    logic [REM_W-1:0]  remaining_reg;
    logic [REM_W-1:0]  remaining_next;
    logic              accept;
    logic              pop;
    logic              room;
    logic              head_valid;
    result_t           head;
    decode_t           dec;

    assign accept = byte_stream.valid && room;
    assign pop    = head_valid && code_stream.ready;

    assign byte_stream.ready      = room;
    assign code_stream.valid      = head_valid;
    assign code_stream.code_point = head.code_point;
    assign code_stream.result_kind = head.result_kind;
    assign code_stream.last       = head.last;

    pu8d_decode u_decode (
        .data_byte (byte_stream.data_byte),
        .partial   (partial_reg),
        .remaining (remaining_reg),
        .dec       (dec)
    );

    pu8d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (accept),
        .push       (dec.push),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .room       (room)
    );

    // advance the sequence state only on an accepted byte
    assign partial_next   = accept ? dec.partial_next   : partial_reg;
    assign remaining_next = accept ? dec.remaining_next : remaining_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            remaining_reg <= '0;
        end
        else
        begin
            partial_reg   <= partial_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pu8d_checker.sv
// ----------------------------------------------------------------------------
// pu8d_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "permissive_utf8_decoder_defines.svh"

module pu8d_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic [pu8d_pkg::BYTE_W-1:0]   data_byte,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [pu8d_pkg::CP_W-1:0]     code_point,
    input wire logic [pu8d_pkg::KIND_W-1:0]   result_kind,
    input wire logic                          last
);
    import pu8d_pkg::*;

    // an empty output side always has room for a byte
    `PU8D_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // end of string always produces a result, valid in the cycle after the byte is accepted
    `PU8D_ASSERT_NEXT(a_zero_gives_result, clk, rst_n,
        in_valid && in_ready && data_byte == '0, out_valid)

    // a cut-short result that is not last has its partner already buffered
    `PU8D_ASSERT_NEXT(a_cut_has_partner, clk, rst_n,
        out_valid && out_ready && result_kind == KIND_CUT && !last, out_valid)

    // hold a stalled result
    `PU8D_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(code_point) && $stable(result_kind) && $stable(last))

endmodule

bind permissive_utf8_decoder pu8d_checker u_pu8d_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (byte_stream.valid),
    .in_ready    (byte_stream.ready),
    .data_byte   (byte_stream.data_byte),
    .out_valid   (code_stream.valid),
    .out_ready   (code_stream.ready),
    .code_point  (code_stream.code_point),
    .result_kind (code_stream.result_kind),
    .last        (code_stream.last)
);

`default_nettype wire
